// ----- rtl/cag_pkg.sv -----
package cag_pkg;

   localparam int MAX_TAB_BITS = 12;
   localparam int CSR_IDX_W    = 2;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_EXP = 2'd1;

   localparam logic [23:0] MAX_GAIN_RST = 24'd65536;
   localparam logic [23:0] GAIN_EXP_RST = 24'd1116;

   localparam logic [30:0] ONE30 = 31'h4000_0000;

   // integer square root, one result bit per pass
   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      v    = val;
      res  = '0;
      bitv = 64'h4000_0000_0000_0000;
      for (int s = 0; s < 32; s++) begin
         if (bitv > v) bitv = bitv >> 2;
      end
      for (int s = 0; s < 32; s++) begin
         if (bitv != 0) begin
            if (v >= res + bitv) begin
               v   = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   // log2(1 + i/2^b) in Q.16 by repeated squaring
   function automatic logic [16:0] log_entry(input int b, input int i);
      logic [63:0] m;
      logic [15:0] bits;
      m    = 64'h4000_0000 + (64'(i) << (30 - b));
      bits = '0;
      for (int j = 15; j >= 0; j--) begin
         m = (m * m) >> 30;
         if (m >= 64'h8000_0000) begin
            m       = m >> 1;
            bits[j] = 1'b1;
         end
      end
      if (i == (1 << b)) return 17'd65536;
      return {1'b0, bits};
   endfunction

   // 2^(-i/2^b) in Q.30 as a product of 2^(-2^-j) factors
   function automatic logic [30:0] exp_entry(input int b, input int i);
      logic [63:0] c [0:MAX_TAB_BITS];
      logic [63:0] r;
      c[0] = 64'h2000_0000;
      c[1] = isqrt64(64'h0800_0000_0000_0000);
      for (int j = 2; j <= MAX_TAB_BITS; j++) begin
         c[j] = (j <= b) ? isqrt64(c[j-1] << 30) : '0;
      end
      r = 64'h4000_0000;
      for (int j = 1; j <= MAX_TAB_BITS; j++) begin
         if (j <= b && ((i >> (b - j)) & 1) != 0) r = (r * c[j]) >> 30;
      end
      if (i == (1 << b)) return 31'h2000_0000;
      return r[30:0];
   endfunction

endpackage

// ----- rtl/cosine_antenna_gain.sv -----
// Cosine-pattern antenna gain, one direction quaternion per request.
// 13 register stages from request acceptance to rsp_valid. Throughput: one request
// per cycle unless the output stalls; each stage holds only while the one after it
// is full and stalled, so bubbles close up and req_ready stays high meanwhile.
// Reset: synchronous, active high; clears all stage valid bits and loads
// max_gain = 1.0 and gain_exponent = 1116/256. Tables are constants, no fill.
module cosine_antenna_gain #(
   parameter int LOG_TABLE_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [15:0]             req_quat_w,
   input  logic signed [15:0]             req_quat_x,
   input  logic signed [15:0]             req_quat_y,
   input  logic signed [15:0]             req_quat_z,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [23:0]                    rsp_gain,
   output logic                           rsp_range_flag,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cag_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [23:0]                    csr_wdata
);
   import cag_pkg::*;

   localparam int NS   = 13;                      // pipeline depth
   localparam int TABN = (1 << LOG_TABLE_BITS) + 1;
   localparam int LSH  = 30 - LOG_TABLE_BITS;     // log interpolation bits
   localparam int ESH  = 16 - LOG_TABLE_BITS;     // exp interpolation bits
   localparam int LDW  = 17 + LSH;
   localparam int EDW  = 31 + ESH;

   typedef logic [16:0] log_rom_type [TABN];
   typedef logic [30:0] exp_rom_type [TABN];

   function automatic log_rom_type build_log_rom();
      log_rom_type t;
      for (int i = 0; i < TABN; i++) t[i] = log_entry(LOG_TABLE_BITS, i);
      return t;
   endfunction

   function automatic exp_rom_type build_exp_rom();
      exp_rom_type t;
      for (int i = 0; i < TABN; i++) t[i] = exp_entry(LOG_TABLE_BITS, i);
      return t;
   endfunction

   localparam log_rom_type LOG_ROM = build_log_rom();
   localparam exp_rom_type EXP_ROM = build_exp_rom();

   // ---------------------------------------------------------------------
   // Configuration registers; the port never stalls.
   // ---------------------------------------------------------------------
   logic [23:0] max_gain_ff;
   logic [23:0] gain_exp_ff;

   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // Flow control: a stage loads when it is empty or its successor loads.
   // ---------------------------------------------------------------------
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || rsp_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         max_gain_ff <= MAX_GAIN_RST;
         gain_exp_ff <= GAIN_EXP_RST;
      end else begin
         if (en[0]) vld_ff[0] <= req_valid;
         for (int i = 1; i < NS; i++) begin
            if (en[i]) vld_ff[i] <= vld_ff[i-1];
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_MAX_GAIN: max_gain_ff <= csr_wdata;
               CSR_GAIN_EXP: gain_exp_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 0: squares, summed by sign.
   // ---------------------------------------------------------------------
   logic signed [31:0] sq_w, sq_x, sq_y, sq_z;
   logic [31:0] pos0_in, neg0_in, pos0_ff, neg0_ff;

   assign sq_w    = req_quat_w * req_quat_w;
   assign sq_x    = req_quat_x * req_quat_x;
   assign sq_y    = req_quat_y * req_quat_y;
   assign sq_z    = req_quat_z * req_quat_z;
   assign pos0_in = $unsigned(sq_w) + $unsigned(sq_x);
   assign neg0_in = $unsigned(sq_y) + $unsigned(sq_z);

   // ---------------------------------------------------------------------
   // Stage 1: cosine, clamp to [-1,1], fold into h = (1+d)/2.
   // ---------------------------------------------------------------------
   logic signed [33:0] d1, hs1;
   logic [30:0] h1_in, h1_ff;
   logic        flag1_in;

   always_comb begin
      d1       = $signed({2'b00, pos0_ff}) - $signed({2'b00, neg0_ff});
      flag1_in = 1'b0;
      if (d1 > $signed({3'b000, ONE30})) begin
         d1       = $signed({3'b000, ONE30});
         flag1_in = 1'b1;
      end else if (d1 < -$signed({3'b000, ONE30})) begin
         d1       = -$signed({3'b000, ONE30});
         flag1_in = 1'b1;
      end
      hs1   = d1 + $signed({3'b000, ONE30});
      h1_in = hs1[31:1];
   end

   // ---------------------------------------------------------------------
   // Stages 2-3: normalise h so its top set bit lands at bit 30.
   // ---------------------------------------------------------------------
   logic [30:0] hn2_in, hn2_ff, hn3_in, hn3_ff;
   logic [4:0]  lz2_in, lz2_ff, lz3_in, lz3_ff;

   always_comb begin
      hn2_in = h1_ff;
      lz2_in = '0;
      if (hn2_in[30:15] == '0) begin
         hn2_in = hn2_in << 16;
         lz2_in = lz2_in + 5'd16;
      end
      if (hn2_in[30:23] == '0) begin
         hn2_in = hn2_in << 8;
         lz2_in = lz2_in + 5'd8;
      end
   end

   always_comb begin
      hn3_in = hn2_ff;
      lz3_in = lz2_ff;
      if (hn3_in[30:27] == '0) begin
         hn3_in = hn3_in << 4;
         lz3_in = lz3_in + 5'd4;
      end
      if (hn3_in[30:29] == '0) begin
         hn3_in = hn3_in << 2;
         lz3_in = lz3_in + 5'd2;
      end
      if (!hn3_in[30]) begin
         hn3_in = hn3_in << 1;
         lz3_in = lz3_in + 5'd1;
      end
   end

   // ---------------------------------------------------------------------
   // Stages 4-6: log2 table read, interpolation, magnitude of log2 h.
   // ---------------------------------------------------------------------
   logic [LOG_TABLE_BITS:0] lidx4;
   logic [16:0]    l0_4_ff, l1_4_ff, l0_5_ff;
   logic [LSH-1:0] rem4_ff;
   logic [4:0]     lz4_ff, lz5_ff;
   logic [LDW-1:0] ld5_in, ld5_ff;
   logic [16:0]    lint6;
   logic [20:0]    lmag6_in, lmag6_ff;

   assign lidx4    = {1'b0, hn3_ff[29:LSH]};
   assign ld5_in   = LDW'(l1_4_ff - l0_4_ff) * LDW'(rem4_ff);
   assign lint6    = l0_5_ff + 17'(ld5_ff >> LSH);
   assign lmag6_in = {lz5_ff, 16'd0} - 21'(lint6);

   // ---------------------------------------------------------------------
   // Stages 7-10: scale by exponent, exp2 table read and interpolation.
   // ---------------------------------------------------------------------
   logic [44:0]    np7_in, np7_ff;
   logic [35:0]    n8;
   logic [LOG_TABLE_BITS:0] eidx8;
   logic [30:0]    a8_ff, b8_ff, a9_ff;
   logic [ESH-1:0] erem8_ff;
   logic [EDW-1:0] ed9_in, ed9_ff;
   logic [30:0]    v10_in, v10_ff;
   logic [4:0]     kl_ff [8:11];
   logic [11:8]    kbig_ff;

   assign np7_in = 45'(lmag6_ff) * 45'(gain_exp_ff);
   assign n8     = np7_ff[44:9];
   assign eidx8  = {1'b0, n8[15:ESH]};
   assign ed9_in = EDW'(a8_ff - b8_ff) * EDW'(erem8_ff);
   assign v10_in = a9_ff - 31'(ed9_ff >> ESH);

   // ---------------------------------------------------------------------
   // Stages 11-12: apply peak gain, shift by integer exponent, saturate.
   // ---------------------------------------------------------------------
   logic [54:0] prod11_in, prod11_ff;
   logic [54:0] sh12;
   logic [5:0]  shamt12;
   logic        sat12;
   logic [23:0] gain12_in, gain12_ff;
   logic [NS-1:1] flag_ff;
   logic [NS-2:2] hz_ff;

   assign prod11_in = 55'(max_gain_ff) * 55'(v10_ff);

   always_comb begin
      shamt12 = 6'd30 + {1'b0, kl_ff[11]};
      sh12    = prod11_ff >> shamt12;
      sat12   = 1'b0;
      if (hz_ff[11]) begin
         gain12_in = (gain_exp_ff == '0) ? max_gain_ff : '0;
      end else if (kbig_ff[11]) begin
         gain12_in = '0;
      end else if (sh12[54:24] != '0) begin
         gain12_in = '1;
         sat12     = 1'b1;
      end else begin
         gain12_in = sh12[23:0];
      end
   end

   assign rsp_gain       = gain12_ff;
   assign rsp_range_flag = flag_ff[NS-1];

   // ---------------------------------------------------------------------
   // Payload registers; advance with their stage enable.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (en[0]) begin
         pos0_ff <= pos0_in;
         neg0_ff <= neg0_in;
      end
      if (en[1]) begin
         h1_ff      <= h1_in;
         flag_ff[1] <= flag1_in;
      end
      if (en[2]) begin
         hn2_ff   <= hn2_in;
         lz2_ff   <= lz2_in;
         hz_ff[2] <= (h1_ff == '0);
      end
      if (en[3]) begin
         hn3_ff <= hn3_in;
         lz3_ff <= lz3_in;
      end
      if (en[4]) begin
         l0_4_ff <= LOG_ROM[lidx4];
         l1_4_ff <= LOG_ROM[lidx4 + 1'b1];
         rem4_ff <= hn3_ff[LSH-1:0];
         lz4_ff  <= lz3_ff;
      end
      if (en[5]) begin
         ld5_ff  <= ld5_in;
         l0_5_ff <= l0_4_ff;
         lz5_ff  <= lz4_ff;
      end
      if (en[6]) lmag6_ff <= lmag6_in;
      if (en[7]) np7_ff <= np7_in;
      if (en[8]) begin
         a8_ff      <= EXP_ROM[eidx8];
         b8_ff      <= EXP_ROM[eidx8 + 1'b1];
         erem8_ff   <= n8[ESH-1:0];
         kl_ff[8]   <= n8[20:16];
         kbig_ff[8] <= (n8[35:16] >= 20'd25);
      end
      if (en[9]) begin
         ed9_ff <= ed9_in;
         a9_ff  <= a8_ff;
      end
      if (en[10]) v10_ff <= v10_in;
      if (en[11]) prod11_ff <= prod11_in;
      if (en[12]) gain12_ff <= gain12_in;
      for (int i = 9; i <= 11; i++) begin
         if (en[i]) begin
            kl_ff[i]   <= kl_ff[i-1];
            kbig_ff[i] <= kbig_ff[i-1];
         end
      end
      for (int i = 2; i < NS; i++) begin
         if (en[i]) flag_ff[i] <= (i == NS - 1) ? (flag_ff[i-1] | sat12) : flag_ff[i-1];
      end
      for (int i = 3; i < NS - 1; i++) begin
         if (en[i]) hz_ff[i] <= hz_ff[i-1];
      end
   end

`ifndef SYNTH
   // h never exceeds one after the clamp
   a_h_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] |-> (h1_ff <= ONE30))
      else $error("h above one after clamp");

   // a non-zero h is fully normalised after the second shift stage
   a_norm: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[3] && !hz_ff[3]) |-> hn3_ff[30])
      else $error("normaliser left leading zero");

   // log magnitude stays within thirty octaves
   a_lmag: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[6] && !hz_ff[6]) |-> (lmag6_ff <= 21'd1966080))
      else $error("log magnitude out of range");
`endif

endmodule

// ----- tb/cosine_antenna_gain_tb.sv -----
`timescale 1ns / 100ps

module cosine_antenna_gain_tb;
   import cag_pkg::*;

   typedef longint unsigned u64_type;

   localparam int      TAB_BITS    = 8;
   localparam int      TAB_LEN     = (1 << TAB_BITS) + 1;
   localparam u64_type ONE_Q30     = u64_type'(1) << 30;
   localparam int      PIPE_DEPTH  = 13;
   localparam int      PHASES      = 6;
   localparam int      PHASE_REQS  = 150;
   localparam int      HOLD_CYCLES = 64;
   localparam int      HOLD_AT [2] = '{300, 600};
   localparam real     TWO_PI      = 6.283185307179586;
   localparam real     HALF_PI     = 1.570796326794897;

   // Q1.15 corner values
   localparam logic [15:0] Q_MIN = 16'h8000;
   localparam logic [15:0] Q_MAX = 16'h7FFF;
   localparam logic [15:0] EDGE_VALS [5] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};

   typedef struct packed {
      logic [23:0] gain;
      logic        range_flag;
   } gain_rsp_type;

   typedef enum logic [1:0] {ROW_QUAT, ROW_SET_MAX_GAIN, ROW_SET_GAIN_EXP} row_kind_type;
   typedef enum logic {CHK_MODEL, CHK_FIXED} row_chk_type;

   // one directed step: a request, or a register write carrying its data in value
   typedef struct packed {
      row_kind_type kind;
      row_chk_type  chk;
      logic [15:0]  w;
      logic [15:0]  x;
      logic [15:0]  y;
      logic [15:0]  z;
      logic [23:0]  value;
      logic         flag;
   } dir_row_type;

   localparam int DIR_ROWS = 30;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      // reset setting: peak 1.0, exponent 1116/256
      // boresight exactly: d = 1, so the peak comes back untouched
      '{ROW_QUAT, CHK_FIXED, Q_MIN, 16'h0000, 16'h0000, 16'h0000, 24'd65536, 1'b0},
      // d = 2: clamp to 1 and flag it
      '{ROW_QUAT, CHK_FIXED, Q_MIN, Q_MIN, 16'h0000, 16'h0000, 24'd65536, 1'b1},
      '{ROW_QUAT, CHK_FIXED, 16'h0000, Q_MIN, 16'h0000, 16'h0000, 24'd65536, 1'b0},
      // straight behind: h is zero, gain zero
      '{ROW_QUAT, CHK_FIXED, 16'h0000, 16'h0000, Q_MIN, 16'h0000, 24'd0, 1'b0},
      // d = -2: clamp to -1 and flag it
      '{ROW_QUAT, CHK_FIXED, 16'h0000, 16'h0000, Q_MIN, Q_MIN, 24'd0, 1'b1},
      // one LSB below -1
      '{ROW_QUAT, CHK_FIXED, 16'h0000, 16'h0000, 16'h0001, Q_MIN, 24'd0, 1'b1},
      // one LSB above -1: h truncates to zero, no clamp
      '{ROW_QUAT, CHK_FIXED, 16'h0001, 16'h0000, 16'h0000, Q_MIN, 24'd0, 1'b0},
      // null quaternion: d = 0
      '{ROW_QUAT, CHK_MODEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'd0, 1'b0},
      '{ROW_QUAT, CHK_MODEL, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 24'd0, 1'b0},
      '{ROW_QUAT, CHK_MODEL, Q_MAX, 16'h0000, 16'h0000, 16'h0000, 24'd0, 1'b0},
      // d = -1 LSB: h just under one half, deepest log segment
      '{ROW_QUAT, CHK_MODEL, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 24'd0, 1'b0},
      '{ROW_QUAT, CHK_MODEL, 16'h5A82, 16'h0000, 16'h5A82, 16'h0000, 24'd0, 1'b0},
      '{ROW_QUAT, CHK_MODEL, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 24'd0, 1'b0},
      // largest peak gain
      '{ROW_SET_MAX_GAIN, CHK_MODEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'hFFFFFF, 1'b0},
      '{ROW_QUAT, CHK_FIXED, Q_MIN, 16'h0000, 16'h0000, 16'h0000, 24'hFFFFFF, 1'b0},
      '{ROW_QUAT, CHK_MODEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'd0, 1'b0},
      // zero exponent: every direction gives the peak, even h zero
      '{ROW_SET_GAIN_EXP, CHK_MODEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'd0, 1'b0},
      '{ROW_QUAT, CHK_FIXED, 16'h0000, 16'h0000, Q_MIN, 16'h0000, 24'hFFFFFF, 1'b0},
      '{ROW_QUAT, CHK_FIXED, 16'h3039, 16'hF752, 16'h7530, 16'hFFF9, 24'hFFFFFF, 1'b0},
      '{ROW_QUAT, CHK_FIXED, Q_MIN, Q_MIN, 16'h0000, 16'h0000, 24'hFFFFFF, 1'b1},
      // largest exponent
      '{ROW_SET_GAIN_EXP, CHK_MODEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'hFFFFFF, 1'b0},
      '{ROW_QUAT, CHK_MODEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'd0, 1'b0},
      '{ROW_QUAT, CHK_MODEL, Q_MAX, 16'h0000, 16'h0000, 16'h0000, 24'd0, 1'b0},
      '{ROW_QUAT, CHK_FIXED, Q_MIN, 16'h0000, 16'h0000, 16'h0000, 24'hFFFFFF, 1'b0},
      // zero peak gain
      '{ROW_SET_MAX_GAIN, CHK_MODEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'd0, 1'b0},
      '{ROW_QUAT, CHK_FIXED, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'd0, 1'b0},
      '{ROW_QUAT, CHK_FIXED, Q_MAX, 16'h0000, 16'h0000, 16'h0000, 24'd0, 1'b0},
      // one LSB of peak, unit exponent
      '{ROW_SET_MAX_GAIN, CHK_MODEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'd1, 1'b0},
      '{ROW_SET_GAIN_EXP, CHK_MODEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'd256, 1'b0},
      '{ROW_QUAT, CHK_MODEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'd0, 1'b0}
   };

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic signed [15:0]   req_quat_w     = '0;
   logic signed [15:0]   req_quat_x     = '0;
   logic signed [15:0]   req_quat_y     = '0;
   logic signed [15:0]   req_quat_z     = '0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [23:0]          rsp_gain;
   logic                 rsp_range_flag;
   logic                 csr_valid      = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index      = CSR_MAX_GAIN;
   logic [23:0]          csr_wdata      = '0;

   // predictor copy of the tables and registers
   u64_type     log2_q16 [TAB_LEN];
   u64_type     pow2_q30 [TAB_LEN];
   logic [23:0] peak_gain = MAX_GAIN_RST;
   logic [23:0] beam_exp  = GAIN_EXP_RST;

   gain_rsp_type gains_due [$];
   int           mismatches = 0;
   int           reqs_taken = 0;
   bit           tx_idle_on = 1'b1;
   bit           rx_idle_on = 1'b1;

   cosine_antenna_gain #(.LOG_TABLE_BITS(TAB_BITS)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_quat_w     (req_quat_w),
      .req_quat_x     (req_quat_x),
      .req_quat_y     (req_quat_y),
      .req_quat_z     (req_quat_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_gain       (rsp_gain),
      .rsp_range_flag (rsp_range_flag),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin : clock_gen
      forever #10 clock = ~clock;
   end

   // bail out if the handshakes ever lock up
   initial begin : watchdog
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // bitwise integer square root, one result bit per pass
   function automatic u64_type int_sqrt(input u64_type val);
      u64_type left;
      u64_type root;
      u64_type probe;
      left  = val;
      root  = 0;
      probe = u64_type'(1) << 62;
      while (probe > left) probe = probe >> 2;
      while (probe != 0) begin
         if (left >= root + probe) begin
            left = left - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Fill the log2 table by repeated squaring and the exp2 table as a product
   // of 2^(-2^-j) factors, each factor the square root of the one before.
   initial begin : build_tables
      u64_type     root_step [1:TAB_BITS];
      u64_type     m;
      u64_type     r;
      logic [15:0] bits;
      root_step[1] = int_sqrt(u64_type'(1) << 59);
      for (int j = 2; j <= TAB_BITS; j++) root_step[j] = int_sqrt(root_step[j-1] << 30);
      for (int i = 0; i < TAB_LEN - 1; i++) begin
         m    = ONE_Q30 + (u64_type'(i) << (30 - TAB_BITS));
         bits = '0;
         for (int j = 15; j >= 0; j--) begin
            m = (m * m) >> 30;
            if (m >= (ONE_Q30 << 1)) begin
               m       = m >> 1;
               bits[j] = 1'b1;
            end
         end
         log2_q16[i] = bits;
         r = ONE_Q30;
         for (int j = 1; j <= TAB_BITS; j++) begin
            if (((i >> (TAB_BITS - j)) & 1) != 0) r = (r * root_step[j]) >> 30;
         end
         pow2_q30[i] = r;
      end
      log2_q16[TAB_LEN-1] = 65536;
      pow2_q30[TAB_LEN-1] = ONE_Q30 >> 1;
   end

   // Gain toward one direction: h = cos^2(angle/2) from the quaternion, then
   // peak * h^(exponent/2) through the log2 and exp2 tables.
   function automatic gain_rsp_type cos_pattern_gain(input logic signed [15:0] qw, qx, qy, qz);
      longint       dot;
      u64_type      half;
      u64_type      frac;
      u64_type      idx;
      u64_type      part;
      u64_type      lg;
      u64_type      lmag;
      u64_type      expo;
      u64_type      shift;
      u64_type      a;
      u64_type      b;
      u64_type      v;
      u64_type      g;
      int           p;
      gain_rsp_type res;
      res.range_flag = 1'b0;
      dot = longint'(qw) * qw + longint'(qx) * qx - longint'(qy) * qy - longint'(qz) * qz;
      if (dot > longint'(ONE_Q30)) begin
         dot            = longint'(ONE_Q30);
         res.range_flag = 1'b1;
      end
      if (dot < -longint'(ONE_Q30)) begin
         dot            = -longint'(ONE_Q30);
         res.range_flag = 1'b1;
      end
      half = u64_type'(dot + longint'(ONE_Q30)) >> 1;
      if (half == 0) begin
         g = (beam_exp == 0) ? u64_type'(peak_gain) : 0;
      end else begin
         // log2 magnitude in Q.16: integer part from the leading one, fraction by table
         p = 30;
         while (((half >> p) & 1) == 0) p--;
         frac = (half - (u64_type'(1) << p)) << (30 - p);
         idx  = frac >> (30 - TAB_BITS);
         part = frac & ((u64_type'(1) << (30 - TAB_BITS)) - 1);
         lg   = log2_q16[idx] +
                (((log2_q16[idx+1] - log2_q16[idx]) * part) >> (30 - TAB_BITS));
         lmag = u64_type'(30 - p) * 65536 - lg;
         // scale by exponent/2 (Q16.8 halved), then 2^-n by whole shift and table
         expo  = (lmag * beam_exp) >> 9;
         shift = 30 + (expo >> 16);
         idx   = (expo & 16'hFFFF) >> (16 - TAB_BITS);
         part  = expo & ((u64_type'(1) << (16 - TAB_BITS)) - 1);
         a     = pow2_q30[idx];
         b     = pow2_q30[idx+1];
         v     = a - (((a - b) * part) >> (16 - TAB_BITS));
         g     = (shift >= 64) ? 0 : (u64_type'(peak_gain) * v) >> shift;
      end
      if (g > 24'hFFFFFF) begin
         g              = 24'hFFFFFF;
         res.range_flag = 1'b1;
      end
      res.gain = g[23:0];
      return res;
   endfunction

   function automatic logic signed [15:0] sat_q15(input int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   // Offer one request; idle first now and then. Valid stays high from the
   // previous request when there is no gap, so it is never dropped and raised
   // in the same step.
   task automatic offer_quat(input logic signed [15:0] qw, qx, qy, qz,
                             input row_chk_type chk, input gain_rsp_type known);
      @(negedge clock);
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_quat_w <= qw;
      req_quat_x <= qx;
      req_quat_y <= qy;
      req_quat_z <= qz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gains_due.push_back(chk == CHK_FIXED ? known : cos_pattern_gain(qw, qx, qy, qz));
      reqs_taken++;
   endtask

   // Drop the request channel, let the pipe drain, then write one register.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [23:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      while (gains_due.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_MAX_GAIN) peak_gain = data;
      else beam_exp = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Result side: random stall bursts, plus a long hold-off at set request
   // counts so the pipe fills up and pushes back on the sender.
   initial begin : result_sink
      int burst;
      int hold_idx;
      burst    = 0;
      hold_idx = 0;
      forever begin
         @(negedge clock);
         if (hold_idx < 2 && reqs_taken >= HOLD_AT[hold_idx]) begin
            hold_idx++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (burst > 0) begin
            burst--;
            rsp_ready <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 7) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare every accepted result with the oldest outstanding prediction.
   always @(posedge clock) begin : check_results
      gain_rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (gains_due.size() == 0) begin
            $error("unexpected result: gain %0d range_flag %0b", rsp_gain, rsp_range_flag);
            mismatches++;
         end else begin
            due = gains_due.pop_front();
            if (rsp_gain !== due.gain) begin
               $error("gain: expected %0d, got %0d", due.gain, rsp_gain);
               mismatches++;
            end
            if (rsp_range_flag !== due.range_flag) begin
               $error("range_flag: expected %0b, got %0b", due.range_flag, rsp_range_flag);
               mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      gain_rsp_type       known;
      logic signed [15:0] q [4];
      logic [23:0]        cfg_peak;
      logic [23:0]        cfg_exp;
      int                 mode;
      real                ang_a;
      real                ang_b;
      real                ang_c;
      known = '0;

      // hold reset, then release it on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED[i]) begin
         case (DIRECTED[i].kind)
            ROW_SET_MAX_GAIN: write_reg(CSR_MAX_GAIN, DIRECTED[i].value);
            ROW_SET_GAIN_EXP: write_reg(CSR_GAIN_EXP, DIRECTED[i].value);
            default: begin
               known.gain       = DIRECTED[i].value;
               known.range_flag = DIRECTED[i].flag;
               offer_quat(DIRECTED[i].w, DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].z,
                          DIRECTED[i].chk, known);
            end
         endcase
      end

      // random phases, each under its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               cfg_peak = 24'($urandom);
               cfg_exp  = 24'($urandom_range(64, 2048));
            end
            1: begin
               cfg_peak = 24'hFFFFFF;
               cfg_exp  = 24'($urandom_range(1, 255));
            end
            2: begin
               cfg_peak = 24'($urandom);
               cfg_exp  = 24'($urandom);
            end
            3: begin
               cfg_peak = 24'($urandom_range(1, 255));
               cfg_exp  = 24'($urandom_range(256, 20000));
            end
            4: begin
               cfg_peak = 24'($urandom);
               cfg_exp  = 24'($urandom_range(0, 16));
            end
            default: begin
               cfg_peak = MAX_GAIN_RST;
               cfg_exp  = GAIN_EXP_RST;
            end
         endcase
         write_reg(CSR_MAX_GAIN, cfg_peak);
         write_reg(CSR_GAIN_EXP, cfg_exp);
         // no idling at all in the closing phase
         tx_idle_on = (ph != 3) && (ph != PHASES - 1);
         rx_idle_on = (ph != 2) && (ph != PHASES - 1);

         repeat (PHASE_REQS) begin
            mode = $urandom_range(0, 9);
            if (mode <= 5) begin
               // near-unit quaternion: d = cos(2b), spread over the whole pattern;
               // a few LSBs of jitter push some just past the clamp
               ang_a = TWO_PI * $urandom_range(0, 65535) / 65536.0;
               ang_c = TWO_PI * $urandom_range(0, 65535) / 65536.0;
               ang_b = HALF_PI * $urandom_range(0, 65535) / 65536.0;
               if (mode == 4) ang_b = ang_b / 32.0;             // main lobe
               if (mode == 5) ang_b = HALF_PI - ang_b / 32.0;   // deep back lobe
               q[0] = sat_q15($rtoi(32767.0 * $cos(ang_a) * $cos(ang_b))
                              + int'($urandom_range(0, 6)) - 3);
               q[1] = sat_q15($rtoi(32767.0 * $sin(ang_a) * $cos(ang_b))
                              + int'($urandom_range(0, 6)) - 3);
               q[2] = sat_q15($rtoi(32767.0 * $cos(ang_c) * $sin(ang_b))
                              + int'($urandom_range(0, 6)) - 3);
               q[3] = sat_q15($rtoi(32767.0 * $sin(ang_c) * $sin(ang_b))
                              + int'($urandom_range(0, 6)) - 3);
            end else begin
               for (int k = 0; k < 4; k++) begin
                  case (mode)
                     6, 7: q[k] = 16'($urandom);
                     8: q[k] = EDGE_VALS[$urandom_range(0, 4)];
                     default: begin
                        q[k] = 16'sd1 <<< $urandom_range(0, 15);
                        if ($urandom_range(0, 1) == 1) q[k] = -q[k];
                     end
                  endcase
               end
            end
            offer_quat(q[0], q[1], q[2], q[3], CHK_MODEL, known);
         end
      end

      // drop valid, drain, then keep watching for strays
      @(negedge clock);
      req_valid <= 1'b0;
      while (gains_due.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 8) @(posedge clock);
      if (mismatches == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
